### rtl/core/abc_pkg.sv
// ----------------------------------------------------------------------------
// abc_pkg
// Types and constants shared by the brake command datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package abc_pkg;

  localparam int unsigned VelW    = 11;
  localparam int unsigned NeedW   = 12;
  localparam int unsigned RunW    = 10;
  localparam int unsigned CenterW = 11;
  localparam int unsigned CmdW    = 12;
  localparam int unsigned BrakeW  = 8;
  localparam int unsigned GainW   = 6;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 11;

  localparam int SmallSpeed = 3;
  localparam int OffsetEdge = 15;
  localparam int OffsetStep = 10;
  localparam int BrakeLimit = 90;

  localparam logic [CenterW-1:0] CenterReset = 11'd1500;
  localparam logic [LimitW-1:0]  HoldReset   = 8'd3;
  localparam logic [LimitW-1:0]  MaxRunReset = 8'd10;
  localparam logic [GainW-1:0]   GainReset   = 6'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROLL_CENTER  = 3'd0,
    REG_PITCH_CENTER = 3'd1,
    REG_HOLD_THRESH  = 3'd2,
    REG_MAX_RUN      = 3'd3,
    REG_ROLL_GAIN    = 3'd4,
    REG_PITCH_GAIN   = 3'd5
  } abc_reg_e;

  typedef enum logic [3:0] {
    SECTOR_E  = 4'd1,
    SECTOR_NE = 4'd2,
    SECTOR_N  = 4'd3,
    SECTOR_NW = 4'd4,
    SECTOR_W  = 4'd5,
    SECTOR_SW = 4'd6,
    SECTOR_S  = 4'd7,
    SECTOR_SE = 4'd8
  } abc_sector_e;

  typedef struct packed {
    logic signed [NeedW-1:0] roll;
    logic signed [NeedW-1:0] pitch;
    logic signed [NeedW-1:0] roll_full;
  } abc_need_t;

  typedef struct packed {
    logic signed [RunW-1:0]  cnt;
    logic signed [NeedW-1:0] need;
    logic                    over;
  } abc_run_t;

endpackage

`default_nettype wire

### rtl/core/abc_demand.sv
// ----------------------------------------------------------------------------
// abc_demand
// Small-speed zeroing and per-sector selection of the roll and pitch demands.
// ----------------------------------------------------------------------------
`default_nettype none

module abc_demand
  import abc_pkg::*;
(
  input  wire logic [3:0]              desired_i,
  input  wire logic [3:0]              current_i,
  input  wire logic signed [VelW-1:0]  vel_x_i,
  input  wire logic signed [VelW-1:0]  vel_y_i,
  output abc_need_t                    need_o
);

  logic                    differ;
  logic signed [VelW-1:0]  vxz;
  logic signed [VelW-1:0]  vyz;
  logic signed [NeedW-1:0] nx;
  logic signed [NeedW-1:0] ny;

  assign differ = (desired_i != current_i);

  always_comb begin
    vxz = vel_x_i;
    vyz = vel_y_i;
    if (differ && (vel_x_i > -SmallSpeed) && (vel_x_i < SmallSpeed)) vxz = '0;
    if (differ && (vel_y_i > -SmallSpeed) && (vel_y_i < SmallSpeed)) vyz = '0;
  end

  assign nx = -$signed({vxz[VelW-1], vxz});
  assign ny = -$signed({vyz[VelW-1], vyz});

  always_comb begin
    need_o.roll      = '0;
    need_o.pitch     = '0;
    need_o.roll_full = ny;
    if (differ) begin
      case (desired_i)
        SECTOR_E: begin
          need_o.roll = ny;
          if (vxz <= 0) need_o.pitch = nx;
        end
        SECTOR_NE: begin
          if (vyz > 0) need_o.roll = ny;
          if (vxz < 0) need_o.pitch = nx;
        end
        SECTOR_N: begin
          if (vyz >= 0) need_o.roll = ny;
          need_o.pitch = nx;
        end
        SECTOR_NW: begin
          if (vyz > 0) need_o.roll = ny;
          if (vxz > 0) need_o.pitch = nx;
        end
        SECTOR_W: begin
          need_o.roll = ny;
          if (vxz > 0) need_o.pitch = nx;
        end
        SECTOR_SW: begin
          if (vyz < 0) need_o.roll = ny;
          if (vxz > 0) need_o.pitch = nx;
        end
        SECTOR_S: begin
          if (vyz < 0) need_o.roll = ny;
          need_o.pitch = nx;
        end
        SECTOR_SE: begin
          if (vyz < 0) need_o.roll = ny;
          if (vxz < 0) need_o.pitch = nx;
        end
        default: begin
          need_o.roll  = ny;
          need_o.pitch = nx;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/abc_run.sv
// ----------------------------------------------------------------------------
// abc_run
// Next value of a signed run counter and the demand after the hold rule.
// ----------------------------------------------------------------------------
`default_nettype none

module abc_run
  import abc_pkg::*;
(
  input  wire logic signed [RunW-1:0]  run_i,
  input  wire logic signed [NeedW-1:0] need_i,
  input  wire logic [LimitW-1:0]       hold_i,
  input  wire logic [LimitW-1:0]       max_run_i,
  output abc_run_t                     res_o
);

  logic signed [RunW-1:0] thr;
  logic signed [RunW-1:0] mx;

  assign thr = $signed({2'b00, hold_i});
  assign mx  = $signed({2'b00, max_run_i});

  always_comb begin
    res_o.need = need_i;
    if (need_i > 0) begin
      res_o.cnt = ((run_i > 0) ? run_i : '0) + 10'sd1;
      if (res_o.cnt > thr) res_o.need = '0;
    end else if (need_i < 0) begin
      res_o.cnt = ((run_i < 0) ? run_i : '0) - 10'sd1;
      if (res_o.cnt < -thr) res_o.need = '0;
    end else begin
      res_o.cnt = '0;
    end
    res_o.over = (res_o.cnt > mx) || (res_o.cnt < -mx);
  end

endmodule

`default_nettype wire

### rtl/core/abc_shape.sv
// ----------------------------------------------------------------------------
// abc_shape
// Gain, dead-band offsets, clamp and stick centre for one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module abc_shape
  import abc_pkg::*;
(
  input  wire logic signed [NeedW-1:0] need_i,
  input  wire logic [GainW-1:0]        gain_i,
  input  wire logic [CenterW-1:0]      center_i,
  output logic signed [BrakeW-1:0]     brake_o,
  output logic [CmdW-1:0]              cmd_o
);

  localparam int unsigned ProdW = NeedW + GainW + 1;

  logic signed [GainW:0]   gain_s;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW:0]   b0;
  logic signed [ProdW:0]   b1;
  logic signed [ProdW:0]   b2;

  assign gain_s = $signed({1'b0, gain_i});
  assign prod   = need_i * gain_s;
  assign b0     = {prod[ProdW-1], prod};
  assign b1     = (b0 < OffsetEdge) ? (ProdW+1)'(b0 + OffsetStep) : b0;
  assign b2     = (b1 > -OffsetEdge) ? (ProdW+1)'(b1 - OffsetStep) : b1;

  always_comb begin
    if (b2 > BrakeLimit) begin
      brake_o = BrakeW'(BrakeLimit);
    end else if (b2 < -BrakeLimit) begin
      brake_o = BrakeW'(-BrakeLimit);
    end else begin
      brake_o = b2[BrakeW-1:0];
    end
  end

  assign cmd_o = {1'b0, center_i} + {{(CmdW-BrakeW){brake_o[BrakeW-1]}}, brake_o};

endmodule

`default_nettype wire

### rtl/core/axis_brake_command_top.sv
// ----------------------------------------------------------------------------
// axis_brake_command_top
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while m_axis_tready holds no result back;
// the run counters update as an item moves into the result register. Reset
// clears both run counters and sets every configuration register to its default.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_brake_command_top
  import abc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // desired_sector[3:0], current_sector[7:4], vel_x[18:8], vel_y[29:19], zero pad
  input  wire logic [31:0]        s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // roll_cmd[11:0], pitch_cmd[23:12], roll_brake[31:24], pitch_brake[39:32]
  output logic [39:0]             m_axis_tdata
);

  logic [CenterW-1:0] roll_center_q, pitch_center_q;
  logic [LimitW-1:0]  hold_q, max_run_q;
  logic [GainW-1:0]   roll_gain_q, pitch_gain_q;

  logic                   in_valid_q;
  logic [3:0]             des_q, cur_q;
  logic signed [VelW-1:0] vx_q, vy_q;

  logic                    out_valid_q;
  logic [CmdW-1:0]         roll_cmd_q, pitch_cmd_q;
  logic signed [BrakeW-1:0] roll_brake_q, pitch_brake_q;

  logic signed [RunW-1:0] roll_run_q, roll_run_d;
  logic signed [RunW-1:0] pitch_run_q, pitch_run_d;

  logic advance, load;

  abc_need_t               need;
  abc_run_t                roll_res, pitch_res;
  logic signed [NeedW-1:0] roll_demand;
  logic signed [BrakeW-1:0] roll_brake, pitch_brake;
  logic [CmdW-1:0]         roll_cmd, pitch_cmd;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_center_q  <= CenterReset;
      pitch_center_q <= CenterReset;
      hold_q         <= HoldReset;
      max_run_q      <= MaxRunReset;
      roll_gain_q    <= GainReset;
      pitch_gain_q   <= GainReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROLL_CENTER:  roll_center_q  <= cfg_data_i;
        REG_PITCH_CENTER: pitch_center_q <= cfg_data_i;
        REG_HOLD_THRESH:  hold_q         <= cfg_data_i[LimitW-1:0];
        REG_MAX_RUN:      max_run_q      <= cfg_data_i[LimitW-1:0];
        REG_ROLL_GAIN:    roll_gain_q    <= cfg_data_i[GainW-1:0];
        REG_PITCH_GAIN:   pitch_gain_q   <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      des_q <= s_axis_tdata[3:0];
      cur_q <= s_axis_tdata[7:4];
      vx_q  <= $signed(s_axis_tdata[18:8]);
      vy_q  <= $signed(s_axis_tdata[29:19]);
    end
  end

  abc_demand u_demand (
    .desired_i (des_q),
    .current_i (cur_q),
    .vel_x_i   (vx_q),
    .vel_y_i   (vy_q),
    .need_o    (need)
  );

  abc_run u_roll_run (
    .run_i     (roll_run_q),
    .need_i    (need.roll),
    .hold_i    (hold_q),
    .max_run_i (max_run_q),
    .res_o     (roll_res)
  );

  abc_run u_pitch_run (
    .run_i     (pitch_run_q),
    .need_i    (need.pitch),
    .hold_i    (hold_q),
    .max_run_i (max_run_q),
    .res_o     (pitch_res)
  );

  assign roll_demand = roll_res.over ? need.roll_full : roll_res.need;
  assign roll_run_d  = roll_res.over ? '0 : roll_res.cnt;
  assign pitch_run_d = pitch_res.over ? '0 : pitch_res.cnt;

  abc_shape u_roll_shape (
    .need_i   (roll_demand),
    .gain_i   (roll_gain_q),
    .center_i (roll_center_q),
    .brake_o  (roll_brake),
    .cmd_o    (roll_cmd)
  );

  abc_shape u_pitch_shape (
    .need_i   (pitch_res.need),
    .gain_i   (pitch_gain_q),
    .center_i (pitch_center_q),
    .brake_o  (pitch_brake),
    .cmd_o    (pitch_cmd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_run_q  <= '0;
      pitch_run_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        roll_run_q  <= roll_run_d;
        pitch_run_q <= pitch_run_d;
      end
      if (!out_valid_q || m_axis_tready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      roll_cmd_q    <= roll_cmd;
      pitch_cmd_q   <= pitch_cmd;
      roll_brake_q  <= roll_brake;
      pitch_brake_q <= pitch_brake;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {pitch_brake_q, roll_brake_q, pitch_cmd_q, roll_cmd_q};

  a_brake_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (roll_brake_q >= -8'sd90) && (roll_brake_q <= 8'sd90) &&
                    (pitch_brake_q >= -8'sd90) && (pitch_brake_q <= 8'sd90))
    else $error("brake offset outside clamp range");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (roll_run_q <= 10'sd255) && (roll_run_q >= -10'sd255) &&
    (pitch_run_q <= 10'sd255) && (pitch_run_q >= -10'sd255))
    else $error("run counter beyond max run range");

  a_run_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(roll_run_q) && $stable(pitch_run_q))
    else $error("run counter changed without an item moving");

  a_equal_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (des_q == cur_q)) |=> (roll_run_q == '0) && (pitch_run_q == '0))
    else $error("run counters not cleared on matching sectors");

  a_stall_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input item lost while result stalled");

endmodule

`default_nettype wire

### tb/axis_brake_command_top_tb.sv
// ----------------------------------------------------------------------------
// axis_brake_command_top_tb
// Self-checking testbench for the brake command block. A short table of
// directed transfers covers every sector rule, the velocity extremes, the
// small-speed zeroing and the hold and full-brake run rules. Random bursts of
// same-direction travel follow under several register settings, the extremes
// among them, with random idling on both streams. Every result transfer is
// checked field by field against an in-order queue of typed or predicted results.
// ----------------------------------------------------------------------------
module axis_brake_command_top_tb;
  import abc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod     = 20;
  localparam int TimeoutCycles = 200000;
  localparam int PhaseItems    = 128;
  localparam int NumPhases     = 8;
  localparam int LongHold      = 40;
  localparam int SettleCycles  = 4;
  localparam int NumDir        = 15;

  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  typedef struct packed {
    logic [CmdW-1:0]   roll_cmd;
    logic [CmdW-1:0]   pitch_cmd;
    logic [BrakeW-1:0] roll_brake;
    logic [BrakeW-1:0] pitch_brake;
  } brake_cmd_t;

  typedef struct packed {
    logic [3:0]              des;
    logic [3:0]              cur;
    logic signed [VelW-1:0]  vel_x;
    logic signed [VelW-1:0]  vel_y;
    logic [4:0]              reps;
    logic                    typed;
    brake_cmd_t              cmd;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [39:0]        m_axis_tdata;

  // Predictor copy of the registers and run counters.
  int roll_center_q = CenterReset;
  int pitch_center_q = CenterReset;
  int hold_q = HoldReset;
  int max_run_q = MaxRunReset;
  int roll_gain_q = GainReset;
  int pitch_gain_q = GainReset;
  int roll_run = 0;
  int pitch_run = 0;

  brake_cmd_t cmd_q[$];
  int         err_cnt = 0;
  int         items_sent = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  bit         long_hold_req = 1'b0;

  dir_row_t dir_tab [NumDir] = '{
    '{4'd0, 4'd0, 11'sd0, 11'sd0, 5'd1, 1'b1,
      '{12'd1500, 12'd1500, 8'sd0, 8'sd0}},
    '{SECTOR_N, 4'd0, -11'sd1024, 11'sd1023, 5'd1, 1'b1,
      '{12'd1410, 12'd1590, -8'sd90, 8'sd90}},
    '{SECTOR_W, SECTOR_W, 11'sd1023, -11'sd1024, 5'd1, 1'b1,
      '{12'd1500, 12'd1500, 8'sd0, 8'sd0}},
    '{SECTOR_E, 4'd0, -11'sd2, 11'sd3, 5'd1, 1'b0, '0},
    '{SECTOR_NE, 4'd3, -11'sd300, 11'sd40, 5'd1, 1'b0, '0},
    '{SECTOR_N, 4'd0, 11'sd2, -11'sd2, 5'd1, 1'b0, '0},
    '{SECTOR_NW, SECTOR_E, 11'sd500, -11'sd3, 5'd1, 1'b0, '0},
    '{SECTOR_W, 4'd0, 11'sd3, -11'sd700, 5'd1, 1'b0, '0},
    '{SECTOR_SW, 4'd0, 11'sd12, -11'sd12, 5'd1, 1'b0, '0},
    '{SECTOR_S, 4'd0, -11'sd5, -11'sd1000, 5'd1, 1'b0, '0},
    '{SECTOR_SE, 4'd0, -11'sd20, -11'sd9, 5'd1, 1'b0, '0},
    '{4'd9, 4'd0, 11'sd7, 11'sd8, 5'd1, 1'b0, '0},
    '{4'd15, 4'd14, -11'sd1024, -11'sd1024, 5'd1, 1'b0, '0},
    '{4'd0, 4'd1, -11'sd3, 11'sd2, 5'd1, 1'b0, '0},
    '{4'd0, 4'd5, 11'sd6, -11'sd6, 5'd12, 1'b0, '0}
  };

  axis_brake_command_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void advance_run(inout int run, inout int need);
    if (need > 0) begin
      if (run <= 0) run = 0;
      run++;
      if (run > hold_q) need = 0;
    end else if (need < 0) begin
      if (run >= 0) run = 0;
      run--;
      if (run < -hold_q) need = 0;
    end else begin
      run = 0;
    end
  endfunction

  function automatic int shape_brake(int need, int gain);
    int b;
    b = need * gain;
    if (b < OffsetEdge) b += OffsetStep;
    if (b > -OffsetEdge) b -= OffsetStep;
    if (b > BrakeLimit) b = BrakeLimit;
    if (b < -BrakeLimit) b = -BrakeLimit;
    return b;
  endfunction

  function automatic brake_cmd_t predict_brake(logic [3:0] des, logic [3:0] cur,
                                               logic signed [VelW-1:0] vel_x,
                                               logic signed [VelW-1:0] vel_y);
    int vx, vy, rneed, pneed, rb, pb;
    brake_cmd_t r;
    vx = vel_x;
    vy = vel_y;
    rneed = 0;
    pneed = 0;
    if (des != cur) begin
      if (vx > -SmallSpeed && vx < SmallSpeed) vx = 0;
      if (vy > -SmallSpeed && vy < SmallSpeed) vy = 0;
      case (des)
        SECTOR_E: begin
          rneed = -vy;
          if (vx <= 0) pneed = -vx;
        end
        SECTOR_NE: begin
          if (vy > 0) rneed = -vy;
          if (vx < 0) pneed = -vx;
        end
        SECTOR_N: begin
          if (vy >= 0) rneed = -vy;
          pneed = -vx;
        end
        SECTOR_NW: begin
          if (vy > 0) rneed = -vy;
          if (vx > 0) pneed = -vx;
        end
        SECTOR_W: begin
          rneed = -vy;
          if (vx > 0) pneed = -vx;
        end
        SECTOR_SW: begin
          if (vy < 0) rneed = -vy;
          if (vx > 0) pneed = -vx;
        end
        SECTOR_S: begin
          if (vy < 0) rneed = -vy;
          pneed = -vx;
        end
        SECTOR_SE: begin
          if (vy < 0) rneed = -vy;
          if (vx < 0) pneed = -vx;
        end
        default: begin
          rneed = -vy;
          pneed = -vx;
        end
      endcase
    end
    advance_run(roll_run, rneed);
    if (roll_run > max_run_q || roll_run < -max_run_q) begin
      rneed = -vy;
      roll_run = 0;
    end
    advance_run(pitch_run, pneed);
    if (pitch_run > max_run_q || pitch_run < -max_run_q) pitch_run = 0;
    rb = shape_brake(rneed, roll_gain_q);
    pb = shape_brake(pneed, pitch_gain_q);
    r.roll_cmd    = CmdW'(roll_center_q + rb);
    r.pitch_cmd   = CmdW'(pitch_center_q + pb);
    r.roll_brake  = BrakeW'(rb);
    r.pitch_brake = BrakeW'(pb);
    return r;
  endfunction

  function automatic logic signed [VelW-1:0] rand_vel(int dir);
    int mag;
    if (dir == 0) return VelW'(int'($urandom_range(4)) - 2);
    case ($urandom_range(3))
      0:       mag = $urandom_range(4);
      1:       mag = (dir < 0) ? 1024 : 1023;
      default: mag = $urandom_range(1023);
    endcase
    return VelW'((dir > 0) ? mag : -mag);
  endfunction

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ROLL_CENTER:  roll_center_q = data;
      REG_PITCH_CENTER: pitch_center_q = data;
      REG_HOLD_THRESH:  hold_q = data[LimitW-1:0];
      REG_MAX_RUN:      max_run_q = data[LimitW-1:0];
      REG_ROLL_GAIN:    roll_gain_q = data[GainW-1:0];
      REG_PITCH_GAIN:   pitch_gain_q = data[GainW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int rc, int pc, int hold, int max_run, int rg, int pg);
    cfg_write(REG_ROLL_CENTER, CfgDatW'(rc));
    cfg_write(REG_PITCH_CENTER, CfgDatW'(pc));
    cfg_write(REG_HOLD_THRESH, CfgDatW'(hold));
    cfg_write(REG_MAX_RUN, CfgDatW'(max_run));
    cfg_write(REG_ROLL_GAIN, CfgDatW'(rg));
    cfg_write(REG_PITCH_GAIN, CfgDatW'(pg));
    cfg_write(RegSpareA, CfgDatW'($urandom));
    cfg_write(RegSpareB, CfgDatW'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(logic [3:0] des, logic [3:0] cur, logic signed [VelW-1:0] vx,
                           logic signed [VelW-1:0] vy, logic typed, brake_cmd_t cmd);
    brake_cmd_t predicted;
    @(negedge clk_i);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, vy, vx, cur, des};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_brake(des, cur, vx, vy);
    cmd_q.push_back(typed ? cmd : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) flag_error($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  always @(posedge clk_i) begin
    brake_cmd_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[31:24],
             m_axis_tdata[39:32]};
      if (cmd_q.size() == 0) begin
        flag_error($sformatf("result transfer %0h with nothing expected", got));
      end else begin
        want = cmd_q.pop_front();
        check_field("roll_cmd", want.roll_cmd, got.roll_cmd);
        check_field("pitch_cmd", want.pitch_cmd, got.pitch_cmd);
        check_field("roll_brake", $signed(want.roll_brake), $signed(got.roll_brake));
        check_field("pitch_brake", $signed(want.pitch_brake), $signed(got.pitch_brake));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (rst_ni) begin
        m_axis_tready <= (int'($urandom_range(99)) >= rx_stall_pct);
      end
    end
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int         phase_start, len, kind, xdir, ydir, mode;
    bit         paused;
    logic [3:0] des, cur;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].reps) begin
        send_item(dir_tab[i].des, dir_tab[i].cur, dir_tab[i].vel_x, dir_tab[i].vel_y,
                  dir_tab[i].typed, dir_tab[i].cmd);
      end
    end
    drain_results();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: apply_setting(0, 2047, 0, 0, 0, 63);
        1: apply_setting(2047, 0, 255, 255, 63, 0);
        default: apply_setting($urandom_range(2047), $urandom_range(1000, 2000),
                               {3'($urandom), 8'($urandom_range(12))},
                               {3'($urandom), 8'($urandom_range(16))},
                               {5'($urandom), 6'($urandom_range(8))},
                               {5'($urandom), 6'($urandom_range(63))});
      endcase
      mode = phase % 4;
      case (mode)
        1:       begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        3:       begin tx_idle_pct = 23; rx_stall_pct = 23; end
        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      if (phase == 4) long_hold_req = 1'b1;
      paused = 1'b0;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if (phase == 5 && !paused && items_sent - phase_start >= PhaseItems / 2) begin
          paused = 1'b1;
          drain_results();
        end
        kind = $urandom_range(9);
        if (kind < 7) begin
          des  = 4'($urandom_range(15));
          cur  = des + 4'($urandom_range(1, 15));
          xdir = int'($urandom_range(2)) - 1;
          ydir = int'($urandom_range(2)) - 1;
          if (max_run_q <= 20 || $urandom_range(7) == 0) len = $urandom_range(1, max_run_q + 3);
          else len = $urandom_range(1, 30);
          repeat (len) send_item(des, cur, rand_vel(xdir), rand_vel(ydir), 1'b0, '0);
        end else if (kind < 9) begin
          repeat ($urandom_range(1, 4)) begin
            send_item(4'($urandom), 4'($urandom), VelW'($urandom), VelW'($urandom), 1'b0, '0);
          end
        end else begin
          des = 4'($urandom_range(15));
          repeat ($urandom_range(1, 3)) begin
            send_item(des, des, VelW'($urandom), VelW'($urandom), 1'b0, '0);
          end
        end
      end
      drain_results();
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
